@@ design/wlec_pkg.sv @@
package wlec_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int DIGIT_W    = 8;
  localparam int UPPER_W    = 32;
  localparam int OP_W       = 2;
  localparam int SEL_W      = 2;
  localparam int RETRY_W    = 8;

  localparam logic [DIGIT_W-1:0] ERASED             = 8'hFF;
  localparam logic [DIGIT_W:0]   DIGIT_BASE         = 9'd255;
  localparam logic [RETRY_W-1:0] VOTE_RETRIES_RESET = 8'd3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_SET     = 2'd1,
    OP_GET     = 2'd2,
    OP_RESTORE = 2'd3
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_COPY_A  = 2'd0,
    SEL_COPY_B  = 2'd1,
    SEL_WORKING = 2'd2,
    SEL_NONE    = 2'd3
  } sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_CARRY,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [UPPER_W-1:0] a;
    logic [UPPER_W-1:0] b;
    logic [UPPER_W-1:0] w;
  } upper_t;

  function automatic upper_t vote(input upper_t u);
    upper_t r;
    r = u;
    if (u.a != u.b) begin
      if (u.a == u.w) begin
        r.b = u.w;
      end else if (u.b == u.w) begin
        r.a = u.w;
      end else begin
        r.b = u.a;
        r.w = u.a;
      end
    end else begin
      r.w = u.a;
    end
    return r;
  endfunction

endpackage

@@ design/wlec_req_if.sv @@
interface wlec_req_if;
  logic                              valid;
  logic                              ready;
  logic [wlec_pkg::OP_W-1:0]         opcode;
  logic [wlec_pkg::DIGIT_W-1:0]      add_amount;
  logic [wlec_pkg::UPPER_W-1:0]      set_value;
  logic [wlec_pkg::SEL_W-1:0]        copy_select;
  logic [wlec_pkg::UPPER_W-1:0]      copy_value;

  modport source (output valid, opcode, add_amount, set_value, copy_select, copy_value,
                  input ready);
  modport sink (input valid, opcode, add_amount, set_value, copy_select, copy_value,
                output ready);
endinterface

@@ design/wlec_rsp_if.sv @@
interface wlec_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [wlec_pkg::UPPER_W-1:0] energy;
  logic                         carried;

  modport source (output valid, energy, carried, input ready);
  modport sink (input valid, energy, carried, output ready);
endinterface

@@ design/wlec_cfg_if.sv @@
interface wlec_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wlec_pkg::RETRY_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/wlec_ram.sv @@
module wlec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/wear_leveled_energy_counter_core.sv @@
// Wear-leveled energy counter core.
// req: one beat carries a command (add, set, get, restore) with all its fields.
// rsp: one beat per command carries energy (get only, else zero) and carried.
// cfg: one beat writes vote_retries; always ready, write only while idle.
// The low digit sits in a 16-entry slot RAM with a registered read;
// the three upper copies sit in flops. Each command scans the slot RAM from
// slot 0, one slot per cycle, until the first live slot or until all 16
// slots are found erased. Then come an execute state, a carry state on a
// carry, and a finish state. rsp.valid and req.ready rise together, so the
// rsp beat and the next req beat can both be taken in the same cycle.
// req.ready is high only while no command is in work. The rsp beat sits in an
// output register, so the next command runs while rsp is stalled; a finished
// command waits in its finish cycle until that register frees.
// Reset (synchronous, rst high) marks all slots erased through per-slot valid
// bits, clears the upper copies, sets vote_retries to 3 and drops rsp.valid.
module wear_leveled_energy_counter_core (
  input  logic       clk,
  input  logic       rst,
  wlec_req_if.sink   req,
  wlec_rsp_if.source rsp,
  wlec_cfg_if.sink   cfg
);

  wlec_pkg::state_t state;
  wlec_pkg::state_t state_next;

  logic [wlec_pkg::SLOT_AW-1:0]    idx;
  logic                            live_found;
  logic [wlec_pkg::SLOT_AW-1:0]    live_idx;
  logic [wlec_pkg::DIGIT_W-1:0]    live_val;
  wlec_pkg::op_t                   op;
  logic [wlec_pkg::DIGIT_W-1:0]    amount;
  logic [wlec_pkg::UPPER_W-1:0]    setv;
  wlec_pkg::sel_t                  sel;
  logic [wlec_pkg::UPPER_W-1:0]    cval;
  wlec_pkg::upper_t                upper;
  logic                            carry_flag;
  logic [wlec_pkg::RETRY_W-1:0]    vote_retries;
  logic [wlec_pkg::SLOT_COUNT-1:0] slot_valid;
  logic [wlec_pkg::SLOT_COUNT-1:0] slot_valid_next;
  logic                            rd_valid;
  logic                            out_valid;
  logic [wlec_pkg::UPPER_W-1:0]    out_energy;
  logic                            out_carried;

  logic [wlec_pkg::SLOT_AW-1:0] raddr;
  logic [wlec_pkg::DIGIT_W-1:0] rdata;
  logic [wlec_pkg::DIGIT_W-1:0] slot_data;
  logic                         wr_en;
  logic [wlec_pkg::SLOT_AW-1:0] wr_addr;
  logic [wlec_pkg::DIGIT_W-1:0] wr_data;
  logic                         erase_en;
  logic [wlec_pkg::DIGIT_W:0]   sum;
  logic                         add_carry;
  logic [wlec_pkg::DIGIT_W-1:0] add_digit;
  logic [wlec_pkg::SLOT_AW-1:0] add_target;
  logic                         accept;
  logic                         out_load;
  logic                         vote_on;

  wlec_ram #(
    .WIDTH(wlec_pkg::DIGIT_W),
    .DEPTH(wlec_pkg::SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req.ready   = (state == wlec_pkg::ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid;
  assign rsp.energy  = out_energy;
  assign rsp.carried = out_carried;
  assign slot_data   = rd_valid ? rdata : wlec_pkg::ERASED;
  assign vote_on     = (vote_retries != '0);
  assign out_load    = (state == wlec_pkg::ST_FIN) && (!out_valid || rsp.ready);

  always_comb begin
    sum = {1'b0, live_val} + {1'b0, amount};
    if (live_found) begin
      add_carry  = (sum >= wlec_pkg::DIGIT_BASE);
      add_digit  = add_carry ? wlec_pkg::DIGIT_W'(sum - wlec_pkg::DIGIT_BASE)
                             : sum[wlec_pkg::DIGIT_W-1:0];
      add_target = sum[wlec_pkg::DIGIT_W-1:wlec_pkg::DIGIT_W-wlec_pkg::SLOT_AW];
    end else begin
      add_carry  = (amount == wlec_pkg::ERASED);
      add_digit  = add_carry ? '0 : amount;
      add_target = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wlec_pkg::ST_IDLE: begin
        if (accept) state_next = wlec_pkg::ST_SCAN;
      end
      wlec_pkg::ST_SCAN: begin
        if (slot_data != wlec_pkg::ERASED ||
            idx == wlec_pkg::SLOT_AW'(wlec_pkg::SLOT_COUNT - 1)) begin
          state_next = wlec_pkg::ST_EXEC;
        end
      end
      wlec_pkg::ST_EXEC: begin
        if (op == wlec_pkg::OP_ADD && add_carry) state_next = wlec_pkg::ST_CARRY;
        else state_next = wlec_pkg::ST_FIN;
      end
      wlec_pkg::ST_CARRY: state_next = wlec_pkg::ST_FIN;
      wlec_pkg::ST_FIN: begin
        if (out_load) state_next = wlec_pkg::ST_IDLE;
      end
      default: state_next = wlec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    raddr    = '0;
    wr_en    = 1'b0;
    wr_addr  = add_target;
    wr_data  = add_digit;
    erase_en = 1'b0;
    case (state)
      wlec_pkg::ST_SCAN: raddr = idx + 1'b1;
      wlec_pkg::ST_EXEC: begin
        if (op == wlec_pkg::OP_ADD) begin
          wr_en    = 1'b1;
          erase_en = live_found && (add_target != live_idx);
        end else if (op == wlec_pkg::OP_SET) begin
          wr_en   = live_found;
          wr_addr = live_idx;
          wr_data = setv[wlec_pkg::DIGIT_W-1:0];
        end
      end
      default: raddr = '0;
    endcase
  end

  always_comb begin
    slot_valid_next = slot_valid;
    if (wr_en) slot_valid_next[wr_addr] = 1'b1;
    if (erase_en) slot_valid_next[live_idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wlec_pkg::ST_IDLE;
      slot_valid   <= '0;
      upper        <= '0;
      vote_retries <= wlec_pkg::VOTE_RETRIES_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) vote_retries <= cfg.data;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      slot_valid <= slot_valid_next;
      case (state)
        wlec_pkg::ST_EXEC: begin
          case (op)
            wlec_pkg::OP_ADD: begin
              if (add_carry && vote_on) upper <= wlec_pkg::vote(upper);
            end
            wlec_pkg::OP_SET: begin
              upper <= {wlec_pkg::UPPER_W'(setv >> wlec_pkg::DIGIT_W),
                        wlec_pkg::UPPER_W'(setv >> wlec_pkg::DIGIT_W),
                        upper.w};
            end
            wlec_pkg::OP_GET: begin
              if (vote_on) upper <= wlec_pkg::vote(upper);
            end
            default: begin
              case (sel)
                wlec_pkg::SEL_COPY_A:  upper.a <= cval;
                wlec_pkg::SEL_COPY_B:  upper.b <= cval;
                wlec_pkg::SEL_WORKING: upper.w <= cval;
                default: ;
              endcase
            end
          endcase
        end
        wlec_pkg::ST_CARRY: begin
          upper <= {3{upper.w + 1'b1}};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= slot_valid[raddr];
    if (accept) begin
      op     <= wlec_pkg::op_t'(req.opcode);
      amount <= req.add_amount;
      setv   <= req.set_value;
      sel    <= wlec_pkg::sel_t'(req.copy_select);
      cval   <= req.copy_value;
      idx    <= '0;
    end
    if (state == wlec_pkg::ST_SCAN) begin
      idx        <= idx + 1'b1;
      live_found <= (slot_data != wlec_pkg::ERASED);
      live_idx   <= idx;
      live_val   <= slot_data;
    end
    if (state == wlec_pkg::ST_EXEC) carry_flag <= (op == wlec_pkg::OP_ADD) && add_carry;
    if (out_load) begin
      out_carried <= carry_flag;
      if (op == wlec_pkg::OP_GET) begin
        out_energy <= {upper.w[wlec_pkg::UPPER_W-wlec_pkg::DIGIT_W-1:0],
                       live_found ? live_val : {wlec_pkg::DIGIT_W{1'b0}}};
      end else begin
        out_energy <= '0;
      end
    end
  end

  a_carry_no_energy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.carried |-> rsp.energy == '0)
    else $error("carried beat with nonzero energy");

  a_carry_syncs_copies: assert property (@(posedge clk) disable iff (rst)
    state == wlec_pkg::ST_CARRY |=> (upper.a == upper.w && upper.b == upper.w))
    else $error("copies differ after carry");

  a_scan_stops_at_live: assert property (@(posedge clk) disable iff (rst)
    state == wlec_pkg::ST_SCAN && slot_data != wlec_pkg::ERASED
    |=> state == wlec_pkg::ST_EXEC && live_found)
    else $error("scan passed a live slot");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == wlec_pkg::ST_SCAN && idx == '0)
    else $error("accepted beat did not start a scan");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    erase_en |-> wr_en && op == wlec_pkg::OP_ADD && wr_addr != live_idx)
    else $error("erase without a new digit write");

endmodule
